// ===== src/assert_macros.svh =====
// Assertion macros used by the datapath RTL file of the arpeggiator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define HNQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define HNQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/hnq_pkg.sv =====
// Types, codes and the tone period table of the held note arpeggiator.
package hnq_pkg;

  localparam int NOTE_W     = 7;
  localparam int PERIOD_W   = 11;
  localparam int COUNT_W    = 4;
  localparam int TABLE_SIZE = 87;
  localparam int TABLE_ENTRIES = 87;
  localparam int LAST_IDX =
    ((TABLE_ENTRIES < TABLE_SIZE) ? TABLE_ENTRIES : TABLE_SIZE) - 1;

  // Input actions.
  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;

  // Arpeggio styles.
  localparam logic [1:0] STYLE_PLAYED = 2'd0;
  localparam logic [1:0] STYLE_UP     = 2'd1;
  localparam logic [1:0] STYLE_DOWN   = 2'd2;
  localparam logic [1:0] STYLE_UPDOWN = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_TRANSPOSE  = 2'd0;
  localparam logic [1:0] REG_ARP_ENABLE = 2'd1;
  localparam logic [1:0] REG_ARP_STYLE  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [NOTE_W-1:0] note;
  } in_item_t;

  typedef struct packed {
    logic                play;
    logic [NOTE_W-1:0]   played_note;
    logic [PERIOD_W-1:0] period;
    logic                attack_start;
    logic                stop;
    logic                dropped;
    logic [COUNT_W-1:0]  held_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        index;
    logic [NOTE_W-1:0] data;
  } cfg_write_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_ON   = 3'd1,
    KIND_FULL = 3'd2,
    KIND_OFF  = 3'd3,
    KIND_TICK = 3'd4
  } hnq_kind_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic prime;
    logic scan;
    logic fetch;
    logic pick;
    logic emit;
  } hnq_cmd_t;

  typedef struct packed {
    hnq_kind_t kind;
    logic      scan_last;
    logic      out_free;
  } hnq_status_t;

  function automatic logic [PERIOD_W-1:0] period_lookup(input logic [NOTE_W-1:0] idx);
    logic [PERIOD_W-1:0] p;
    case (idx)
      7'd0:  p = 11'h7F1;  7'd1:  p = 11'h780;  7'd2:  p = 11'h713;
      7'd3:  p = 11'h6AD;  7'd4:  p = 11'h64D;  7'd5:  p = 11'h5F3;
      7'd6:  p = 11'h59D;  7'd7:  p = 11'h54D;  7'd8:  p = 11'h500;
      7'd9:  p = 11'h4B8;  7'd10: p = 11'h475;  7'd11: p = 11'h435;
      7'd12: p = 11'h3F8;  7'd13: p = 11'h3BF;  7'd14: p = 11'h389;
      7'd15: p = 11'h356;  7'd16: p = 11'h326;  7'd17: p = 11'h2F9;
      7'd18: p = 11'h2CE;  7'd19: p = 11'h2A6;  7'd20: p = 11'h280;
      7'd21: p = 11'h25C;  7'd22: p = 11'h23A;  7'd23: p = 11'h21A;
      7'd24: p = 11'h1FC;  7'd25: p = 11'h1DF;  7'd26: p = 11'h1C4;
      7'd27: p = 11'h1AB;  7'd28: p = 11'h193;  7'd29: p = 11'h17C;
      7'd30: p = 11'h167;  7'd31: p = 11'h152;  7'd32: p = 11'h13F;
      7'd33: p = 11'h12D;  7'd34: p = 11'h11C;  7'd35: p = 11'h10C;
      7'd36: p = 11'h0FD;  7'd37: p = 11'h0EF;  7'd38: p = 11'h0E2;
      7'd39: p = 11'h0D5;  7'd40: p = 11'h0C9;  7'd41: p = 11'h0BD;
      7'd42: p = 11'h0B3;  7'd43: p = 11'h0A9;  7'd44: p = 11'h09F;
      7'd45: p = 11'h096;  7'd46: p = 11'h08E;  7'd47: p = 11'h086;
      7'd48: p = 11'h07E;  7'd49: p = 11'h077;  7'd50: p = 11'h070;
      7'd51: p = 11'h06A;  7'd52: p = 11'h064;  7'd53: p = 11'h05E;
      7'd54: p = 11'h059;  7'd55: p = 11'h054;  7'd56: p = 11'h04F;
      7'd57: p = 11'h04B;  7'd58: p = 11'h046;  7'd59: p = 11'h042;
      7'd60: p = 11'h03F;  7'd61: p = 11'h03B;  7'd62: p = 11'h038;
      7'd63: p = 11'h034;  7'd64: p = 11'h031;  7'd65: p = 11'h02F;
      7'd66: p = 11'h02C;  7'd67: p = 11'h029;  7'd68: p = 11'h027;
      7'd69: p = 11'h025;  7'd70: p = 11'h023;  7'd71: p = 11'h021;
      7'd72: p = 11'h01F;  7'd73: p = 11'h01D;  7'd74: p = 11'h01B;
      7'd75: p = 11'h01A;  7'd76: p = 11'h018;  7'd77: p = 11'h017;
      7'd78: p = 11'h015;  7'd79: p = 11'h014;  7'd80: p = 11'h013;
      7'd81: p = 11'h012;  7'd82: p = 11'h011;  7'd83: p = 11'h010;
      7'd84: p = 11'h00F;  7'd85: p = 11'h00E;  7'd86: p = 11'h00D;
      default: p = 11'h00D;
    endcase
    return p;
  endfunction

endpackage

// ===== src/hnq_if.sv =====
// Valid/ready channel interfaces for note items, results and register writes.
interface hnq_in_if ();
  logic             valid;
  logic             ready;
  hnq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hnq_out_if ();
  logic              valid;
  logic              ready;
  hnq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hnq_cfg_if ();
  logic               valid;
  logic               ready;
  hnq_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/held_note_queue_arpeggiator_unit.sv =====
// On/off: decode, prime, scan, emit; arp tick: decode, fetch, pick, emit; others: decode, emit.
// Note on and note off walk both queue memories one entry a cycle in the scan.
// One item is in work at a time; the next is taken once the result sits in the output register.
// A waiting result does not block the next item; only a second result waits for out ready.
// Synchronous active-low reset: no notes held, voice silent, configuration registers zero, no clearing pass.
module held_note_queue_arpeggiator_unit #(
  parameter int QUEUE_DEPTH = 8
) (
  input logic       clk,
  input logic       rst_n,
  hnq_in_if.sink    in_if,
  hnq_out_if.source out_if,
  hnq_cfg_if.sink   cfg_if
);

  hnq_pkg::hnq_cmd_t    cmd;
  hnq_pkg::hnq_status_t status;

  // Register writes are always taken.
  assign cfg_if.ready = 1'b1;

  hnq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  hnq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_if.data),
    .cfg_valid (cfg_if.valid),
    .cfg_data  (cfg_if.data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_data  (out_if.data)
  );

endmodule

// ===== src/hnq_ctrl.sv =====
// Sequencing state machine for one note item at a time.
module hnq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hnq_pkg::hnq_status_t status,
  output hnq_pkg::hnq_cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_PRIME  = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_FETCH  = 7'b0010000,
    ST_PICK   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (status.kind)
          hnq_pkg::KIND_ON,
          hnq_pkg::KIND_OFF:  state_nxt = ST_PRIME;
          hnq_pkg::KIND_TICK: state_nxt = ST_FETCH;
          default:            state_nxt = ST_EMIT;
        endcase
      end
      ST_PRIME: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_EMIT;
      end
      ST_FETCH: state_nxt = ST_PICK;
      ST_PICK:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && in_valid;
  assign cmd.decode = (state_r == ST_DECODE);
  assign cmd.prime  = (state_r == ST_PRIME);
  assign cmd.scan   = (state_r == ST_SCAN);
  assign cmd.fetch  = (state_r == ST_FETCH);
  assign cmd.pick   = (state_r == ST_PICK);
  assign cmd.emit   = (state_r == ST_EMIT) && status.out_free;

endmodule

// ===== src/hnq_datapath.sv =====
// Note queues, arpeggio stepping, period lookup and the result register.
`include "assert_macros.svh"

module hnq_datapath #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hnq_pkg::in_item_t    in_data,
  input  logic                 cfg_valid,
  input  hnq_pkg::cfg_write_t  cfg_data,
  input  hnq_pkg::hnq_cmd_t    cmd,
  output hnq_pkg::hnq_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output hnq_pkg::out_item_t   out_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = hnq_pkg::NOTE_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // Configuration registers.
  logic [NW-1:0] transpose_r;
  logic          arp_en_r;
  logic [1:0]    style_r;

  // Queue memories, press order and ascending.
  logic [NW-1:0] pmem [QUEUE_DEPTH];
  logic [NW-1:0] smem [QUEUE_DEPTH];
  logic [NW-1:0] prd_r, srd_r;

  logic [CW-1:0]      held_r;
  logic [AW-1:0]      pos_r;
  logic               asc_r;
  logic               sounding_r;
  hnq_pkg::in_item_t  item_r;
  hnq_pkg::hnq_kind_t kind_r;
  logic [CW-1:0]      idx_r;
  logic               ins_r;
  logic               found_r;
  logic               sfound_r;
  logic [NW-1:0]      carry_r;
  logic [NW-1:0]      play_note_r;
  logic [AW-1:0]      arp_addr_r;
  logic               arp_sorted_r;
  logic               out_valid_r;
  hnq_pkg::out_item_t out_data_r;

  // Classification of the loaded item.
  hnq_pkg::hnq_kind_t kind_c;
  always_comb begin
    case (item_r.action)
      hnq_pkg::ACT_NOTE_ON:
        kind_c = (held_r < DEPTH_C) ? hnq_pkg::KIND_ON : hnq_pkg::KIND_FULL;
      hnq_pkg::ACT_NOTE_OFF:
        kind_c = (held_r != '0) ? hnq_pkg::KIND_OFF : hnq_pkg::KIND_NONE;
      hnq_pkg::ACT_TICK:
        kind_c = (arp_en_r && held_r > CW'(1)) ? hnq_pkg::KIND_TICK : hnq_pkg::KIND_NONE;
      default:
        kind_c = hnq_pkg::KIND_NONE;
    endcase
  end

  // Arpeggio step.
  logic [CW-1:0] top_c, pos_ext, pos_inc, clamp_c, np_c, addr_c;
  logic          asc_c, sel_sorted_c;
  always_comb begin
    top_c   = held_r - CW'(1);
    pos_ext = CW'(pos_r);
    pos_inc = pos_ext + CW'(1);
    clamp_c = pos_ext;
    asc_c   = asc_r;
    if (held_r == CW'(2) || style_r != hnq_pkg::STYLE_UPDOWN) begin
      np_c = (pos_inc > top_c) ? '0 : pos_inc;
      if (held_r == CW'(2) || style_r == hnq_pkg::STYLE_PLAYED) begin
        sel_sorted_c = 1'b0;
        addr_c       = np_c;
      end else if (style_r == hnq_pkg::STYLE_UP) begin
        sel_sorted_c = 1'b1;
        addr_c       = np_c;
      end else begin
        sel_sorted_c = 1'b1;
        addr_c       = top_c - np_c;
      end
    end else begin
      // Clamp a position left high by a note off, then bounce at the ends.
      if (pos_ext > top_c) clamp_c = top_c;
      if (clamp_c >= top_c) asc_c = 1'b0;
      else if (clamp_c == '0) asc_c = 1'b1;
      np_c         = asc_c ? clamp_c + CW'(1) : clamp_c - CW'(1);
      sel_sorted_c = 1'b1;
      addr_c       = np_c;
    end
  end

  // Scan control.
  logic          on_scan, off_scan, at_held, at_top, ins_c, found_c;
  logic [CW-1:0] idx_inc, idx_dec;
  logic [AW-1:0] raddr;
  assign on_scan  = cmd.scan && (kind_r == hnq_pkg::KIND_ON);
  assign off_scan = cmd.scan && (kind_r == hnq_pkg::KIND_OFF);
  assign at_held  = (idx_r == held_r);
  assign at_top   = (idx_r == top_c);
  assign ins_c    = !ins_r && (at_held || srd_r > item_r.note);
  assign found_c  = found_r || (prd_r == item_r.note);
  assign idx_inc  = idx_r + CW'(1);
  assign idx_dec  = idx_r - CW'(1);

  always_comb begin
    if (cmd.scan) begin
      raddr = (idx_inc < DEPTH_C) ? idx_inc[AW-1:0] : '0;
    end else if (cmd.fetch) begin
      raddr = arp_addr_r;
    end else if (cmd.prime) begin
      // Read the first entry ahead of the scan.
      raddr = '0;
    end else begin
      raddr = '0;
    end
  end

  logic          p_we, s_we;
  logic [AW-1:0] p_waddr, s_waddr;
  logic [NW-1:0] p_wdata, s_wdata;
  always_comb begin
    p_we    = 1'b0;
    p_waddr = idx_r[AW-1:0];
    p_wdata = item_r.note;
    s_we    = 1'b0;
    s_waddr = idx_r[AW-1:0];
    s_wdata = item_r.note;
    if (on_scan) begin
      p_we    = at_held;
      s_we    = ins_r || ins_c;
      s_wdata = ins_r ? carry_r : item_r.note;
    end else if (off_scan) begin
      // Close the gap left by the removed note.
      p_we    = found_r;
      p_waddr = idx_dec[AW-1:0];
      p_wdata = prd_r;
      s_we    = sfound_r;
      s_waddr = idx_dec[AW-1:0];
      s_wdata = srd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    if (s_we) smem[s_waddr] <= s_wdata;
    prd_r <= pmem[raddr];
    srd_r <= smem[raddr];
  end

  assign status.kind      = kind_c;
  assign status.scan_last = (kind_r == hnq_pkg::KIND_ON) ? at_held : at_top;
  assign status.out_free  = !out_valid_r || out_ready;

  // Period lookup at note plus transpose, saturated to the table.
  logic signed [8:0]   sum_c;
  logic [NW-1:0]       tidx_c;
  logic [hnq_pkg::PERIOD_W-1:0] period_c;
  always_comb begin
    sum_c = $signed({2'b00, play_note_r}) + $signed({{2{transpose_r[NW-1]}}, transpose_r});
    if (sum_c < 0) begin
      tidx_c = '0;
    end else if (sum_c > $signed(9'(hnq_pkg::LAST_IDX))) begin
      tidx_c = NW'(hnq_pkg::LAST_IDX);
    end else begin
      tidx_c = sum_c[NW-1:0];
    end
    period_c = hnq_pkg::period_lookup(tidx_c);
  end

  logic              play_c, stop_c, drop_c;
  logic [CW+3:0]     held_wide;
  hnq_pkg::out_item_t result_c;
  always_comb begin
    play_c = (kind_r == hnq_pkg::KIND_ON) || (kind_r == hnq_pkg::KIND_TICK) ||
             ((kind_r == hnq_pkg::KIND_OFF) && found_r && held_r != '0);
    stop_c = (kind_r == hnq_pkg::KIND_OFF) && found_r && held_r == '0;
    drop_c = (kind_r == hnq_pkg::KIND_FULL);
    held_wide             = {4'b0000, held_r};
    result_c.play         = play_c;
    result_c.played_note  = play_c ? play_note_r : '0;
    result_c.period       = play_c ? period_c : '0;
    result_c.attack_start = play_c && !sounding_r;
    result_c.stop         = stop_c;
    result_c.dropped      = drop_c;
    result_c.held_count   = held_wide[3:0];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transpose_r <= '0;
      arp_en_r    <= 1'b0;
      style_r     <= hnq_pkg::STYLE_PLAYED;
      held_r      <= '0;
      pos_r       <= '0;
      asc_r       <= 1'b1;
      sounding_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_data.index)
          hnq_pkg::REG_TRANSPOSE:  transpose_r <= cfg_data.data;
          hnq_pkg::REG_ARP_ENABLE: arp_en_r    <= cfg_data.data[0];
          hnq_pkg::REG_ARP_STYLE:  style_r     <= cfg_data.data[1:0];
          default: ;
        endcase
      end
      if (cmd.decode && kind_c == hnq_pkg::KIND_TICK) begin
        pos_r <= np_c[AW-1:0];
        asc_r <= asc_c;
      end
      if (on_scan && at_held) held_r <= held_r + CW'(1);
      if (off_scan && at_top && found_c) held_r <= held_r - CW'(1);
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (play_c) sounding_r <= 1'b1;
        else if (stop_c) sounding_r <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r      <= in_data;
      play_note_r <= in_data.note;
    end
    if (cmd.decode) begin
      kind_r       <= kind_c;
      idx_r        <= '0;
      ins_r        <= 1'b0;
      found_r      <= 1'b0;
      sfound_r     <= 1'b0;
      arp_addr_r   <= addr_c[AW-1:0];
      arp_sorted_r <= sel_sorted_c;
    end
    if (cmd.scan) idx_r <= idx_inc;
    if (on_scan) begin
      if (ins_c) ins_r <= 1'b1;
      carry_r <= srd_r;
    end
    if (off_scan) begin
      found_r  <= found_c;
      sfound_r <= sfound_r || (srd_r == item_r.note);
      // Track the newest note that stays held.
      if (found_r || prd_r != item_r.note) play_note_r <= prd_r;
    end
    if (cmd.pick) play_note_r <= arp_sorted_r ? srd_r : prd_r;
    if (cmd.emit) out_data_r <= result_c;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HNQ_ASSERT(a_held_range, held_r <= DEPTH_C, "held count beyond queue depth")
  `HNQ_ASSERT_IMPL(a_scan_bound, cmd.scan, idx_r <= held_r, "scan ran past the held notes")
  `HNQ_ASSERT_IMPL(a_arp_addr, cmd.pick, CW'(arp_addr_r) < held_r, "arp read outside held notes")
  `HNQ_ASSERT_IMPL(a_play_sounds, out_valid_r && out_data_r.play, sounding_r,
                   "played result while voice silent")

endmodule

// ===== dv/tb_held_note_queue_arpeggiator_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the held note queue arpeggiator with a local voice predictor.
module tb_held_note_queue_arpeggiator_unit;

  localparam int DEPTH = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int END_SETTLE = 20;
  localparam int LONG_HOLD = 250;
  localparam int PHASES = 6;
  localparam int PHASE_BEATS = 50;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int PHASE_XPOSE [PHASES] = '{0, -48, 48, 7, -20, 33};
  localparam bit PHASE_ARP_ON [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  localparam logic [1:0] PHASE_STYLE [PHASES] =
    '{hnq_pkg::STYLE_UPDOWN, hnq_pkg::STYLE_PLAYED, hnq_pkg::STYLE_UP,
      hnq_pkg::STYLE_DOWN, hnq_pkg::STYLE_UPDOWN, hnq_pkg::STYLE_DOWN};

  localparam logic [hnq_pkg::PERIOD_W-1:0] TONE_PERIOD [hnq_pkg::TABLE_SIZE] = '{
    11'h7F1, 11'h780, 11'h713, 11'h6AD, 11'h64D, 11'h5F3, 11'h59D, 11'h54D, 11'h500, 11'h4B8,
    11'h475, 11'h435, 11'h3F8, 11'h3BF, 11'h389, 11'h356, 11'h326, 11'h2F9, 11'h2CE, 11'h2A6,
    11'h280, 11'h25C, 11'h23A, 11'h21A, 11'h1FC, 11'h1DF, 11'h1C4, 11'h1AB, 11'h193, 11'h17C,
    11'h167, 11'h152, 11'h13F, 11'h12D, 11'h11C, 11'h10C, 11'h0FD, 11'h0EF, 11'h0E2, 11'h0D5,
    11'h0C9, 11'h0BD, 11'h0B3, 11'h0A9, 11'h09F, 11'h096, 11'h08E, 11'h086, 11'h07E, 11'h077,
    11'h070, 11'h06A, 11'h064, 11'h05E, 11'h059, 11'h054, 11'h04F, 11'h04B, 11'h046, 11'h042,
    11'h03F, 11'h03B, 11'h038, 11'h034, 11'h031, 11'h02F, 11'h02C, 11'h029, 11'h027, 11'h025,
    11'h023, 11'h021, 11'h01F, 11'h01D, 11'h01B, 11'h01A, 11'h018, 11'h017, 11'h015, 11'h014,
    11'h013, 11'h012, 11'h011, 11'h010, 11'h00F, 11'h00E, 11'h00D
  };

  logic clk = 1'b0;
  logic rst_n;

  hnq_in_if  in_ch ();
  hnq_out_if out_ch ();
  hnq_cfg_if cfg_ch ();

  held_note_queue_arpeggiator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Voice state and register copies, as they stand after reset.
  logic [hnq_pkg::NOTE_W-1:0]        by_press [DEPTH];
  logic [hnq_pkg::NOTE_W-1:0]        ascending [DEPTH];
  int                                held_n = 0;
  int                                arp_idx = 0;
  bit                                arp_rising = 1'b1;
  bit                                voice_on = 1'b0;
  logic [hnq_pkg::NOTE_W-1:0]        cur_note = 7'd43;
  logic signed [hnq_pkg::NOTE_W-1:0] xpose = '0;
  bit                                arp_on = 1'b0;
  logic [1:0]                        arp_mode = hnq_pkg::STYLE_PLAYED;

  hnq_pkg::out_item_t voice_results [$];
  int                 errors = 0;
  bit                 send_gaps = 1'b1;
  bit                 recv_stalls = 1'b1;
  int                 hold_req = 0;
  int                 stall_left = 0;

  task automatic resort_notes();
    logic [hnq_pkg::NOTE_W-1:0] v;
    int j;
    for (int i = 0; i < held_n; i++) begin
      v = by_press[i];
      j = i;
      while (j > 0 && ascending[j-1] > v) begin
        ascending[j] = ascending[j-1];
        j--;
      end
      ascending[j] = v;
    end
  endtask

  task automatic voice_note(input logic [hnq_pkg::NOTE_W-1:0] n,
                            inout hnq_pkg::out_item_t r);
    int idx;
    idx = int'(n) + int'(xpose);
    if (idx < 0) idx = 0;
    if (idx > hnq_pkg::TABLE_SIZE - 1) idx = hnq_pkg::TABLE_SIZE - 1;
    r.play = 1'b1;
    r.played_note = n;
    r.period = TONE_PERIOD[idx];
    r.attack_start = !voice_on;
    voice_on = 1'b1;
    cur_note = n;
  endtask

  task automatic predict_voice(input hnq_pkg::in_item_t it, output hnq_pkg::out_item_t r);
    int hit;
    int top;
    logic [hnq_pkg::NOTE_W-1:0] pick;
    r = '0;
    case (it.action)
      hnq_pkg::ACT_NOTE_ON: begin
        if (held_n < DEPTH) begin
          voice_note(it.note, r);
          by_press[held_n] = it.note;
          held_n++;
          resort_notes();
        end else begin
          r.dropped = 1'b1;
        end
      end
      hnq_pkg::ACT_NOTE_OFF: begin
        hit = held_n;
        for (int i = held_n - 1; i >= 0; i--)
          if (by_press[i] == it.note) hit = i;
        if (hit < held_n) begin
          for (int i = hit; i + 1 < held_n; i++) by_press[i] = by_press[i+1];
          held_n--;
          resort_notes();
          if (held_n == 0) begin
            voice_on = 1'b0;
            r.stop = 1'b1;
          end else begin
            voice_note(by_press[held_n-1], r);
          end
        end
      end
      hnq_pkg::ACT_TICK: begin
        if (arp_on && held_n > 1) begin
          top = held_n - 1;
          if (held_n == 2 || arp_mode != hnq_pkg::STYLE_UPDOWN) begin
            // wrap to the start, also from a position left past the end
            arp_idx = (arp_idx + 1 > top) ? 0 : arp_idx + 1;
            if (held_n == 2 || arp_mode == hnq_pkg::STYLE_PLAYED) pick = by_press[arp_idx];
            else if (arp_mode == hnq_pkg::STYLE_UP) pick = ascending[arp_idx];
            else pick = ascending[top - arp_idx];
          end else begin
            if (arp_idx > top) arp_idx = top;
            if (arp_idx >= top) arp_rising = 1'b0;
            else if (arp_idx == 0) arp_rising = 1'b1;
            arp_idx = arp_rising ? arp_idx + 1 : arp_idx - 1;
            pick = ascending[arp_idx];
          end
          voice_note(pick, r);
        end
      end
      default: ;
    endcase
    r.held_count = held_n[hnq_pkg::COUNT_W-1:0];
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  // Predict on each input beat, compare on each result beat.
  always @(posedge clk) begin : voice_monitor
    hnq_pkg::out_item_t want;
    hnq_pkg::out_item_t got;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          hnq_pkg::REG_TRANSPOSE:  xpose = cfg_ch.data.data;
          hnq_pkg::REG_ARP_ENABLE: arp_on = cfg_ch.data.data[0];
          hnq_pkg::REG_ARP_STYLE:  arp_mode = cfg_ch.data.data[1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_voice(in_ch.data, want);
        voice_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (voice_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = voice_results.pop_front();
          check_field("play", want.play, got.play);
          check_field("played_note", want.played_note, got.played_note);
          check_field("period", want.period, got.period);
          check_field("attack_start", want.attack_start, got.attack_start);
          check_field("stop", want.stop, got.stop);
          check_field("dropped", want.dropped, got.dropped);
          check_field("held_count", want.held_count, got.held_count);
        end
      end
    end
  end

  // Result ready: random stall bursts plus a requested long hold.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end else if (stall_left == 0 && recv_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 17);
    end
    if (stall_left != 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  function automatic hnq_pkg::in_item_t beat(input logic [1:0] act,
                                             input logic [hnq_pkg::NOTE_W-1:0] n);
    hnq_pkg::in_item_t it;
    it.action = act;
    it.note = n;
    return it;
  endfunction

  // Mostly well-formed play: note offs hit held notes, the queue hovers near half full.
  function automatic hnq_pkg::in_item_t random_beat();
    hnq_pkg::in_item_t it;
    int roll;
    roll = $urandom_range(0, 99);
    it.note = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 3) == 0) it.note = 7'($urandom_range(60, 63));
    if (roll < (held_n < 4 ? 45 : 25)) begin
      it.action = hnq_pkg::ACT_NOTE_ON;
    end else if (roll < 65) begin
      it.action = hnq_pkg::ACT_NOTE_OFF;
      if (held_n != 0 && $urandom_range(0, 4) != 0)
        it.note = by_press[$urandom_range(0, held_n - 1)];
    end else if (roll < 96) begin
      it.action = hnq_pkg::ACT_TICK;
    end else begin
      it.action = ACT_SPARE;
    end
    return it;
  endfunction

  // Valid stays high after the beat; wait_results, or a gap in the next call, lowers it.
  task automatic send_beat(input hnq_pkg::in_item_t it, input bit pick_random);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.data = pick_random ? random_beat() : it;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (voice_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [hnq_pkg::NOTE_W-1:0] val);
    @(negedge clk);
    cfg_ch.data.index = idx;
    cfg_ch.data.data = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic test_queue_edges();
    write_reg(hnq_pkg::REG_TRANSPOSE, 7'd0);
    write_reg(hnq_pkg::REG_ARP_ENABLE, 7'd0);
    write_reg(hnq_pkg::REG_ARP_STYLE, 7'(hnq_pkg::STYLE_PLAYED));
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd0), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd127), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_OFF, 7'd55), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_OFF, 7'd127), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_OFF, 7'd0), 1'b0);
    send_beat(beat(hnq_pkg::ACT_TICK, 7'd0), 1'b0);
    send_beat(beat(ACT_SPARE, 7'd127), 1'b0);
    // fill the queue, duplicates included, then one more is refused
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd70), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd12), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd70), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd99), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd5), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd40), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd120), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd33), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_ON, 7'd85), 1'b0);
    send_beat(beat(hnq_pkg::ACT_TICK, 7'd0), 1'b0);
    wait_results();
  endtask

  task automatic test_arp_styles();
    write_reg(hnq_pkg::REG_ARP_ENABLE, 7'd1);
    write_reg(hnq_pkg::REG_ARP_STYLE, 7'(hnq_pkg::STYLE_UPDOWN));
    repeat (3) send_beat(beat(hnq_pkg::ACT_TICK, 7'd0), 1'b0);
    send_beat(beat(hnq_pkg::ACT_NOTE_OFF, 7'd70), 1'b0);
    wait_results();
    write_reg(hnq_pkg::REG_ARP_STYLE, 7'(hnq_pkg::STYLE_PLAYED));
    send_beat(beat(hnq_pkg::ACT_TICK, 7'd0), 1'b0);
    wait_results();
    write_reg(hnq_pkg::REG_ARP_STYLE, 7'(hnq_pkg::STYLE_UP));
    send_beat(beat(hnq_pkg::ACT_TICK, 7'd0), 1'b0);
    wait_results();
    write_reg(hnq_pkg::REG_ARP_STYLE, 7'(hnq_pkg::STYLE_DOWN));
    send_beat(beat(hnq_pkg::ACT_TICK, 7'd0), 1'b0);
    wait_results();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      write_reg(hnq_pkg::REG_TRANSPOSE, 7'(PHASE_XPOSE[p]));
      write_reg(hnq_pkg::REG_ARP_ENABLE, 7'(PHASE_ARP_ON[p]));
      write_reg(hnq_pkg::REG_ARP_STYLE, 7'(PHASE_STYLE[p]));
      repeat (PHASE_BEATS) send_beat('0, 1'b1);
      wait_results();
    end
  endtask

  task automatic test_output_backpressure();
    send_gaps = 1'b0;
    @(posedge clk);
    hold_req = LONG_HOLD;
    repeat (10) send_beat('0, 1'b1);
    wait_results();
    send_gaps = 1'b1;
  endtask

  task automatic test_steady_stream();
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    write_reg(hnq_pkg::REG_TRANSPOSE, 7'(int'($urandom_range(0, 96)) - 48));
    write_reg(hnq_pkg::REG_ARP_ENABLE, 7'd1);
    write_reg(hnq_pkg::REG_ARP_STYLE, 7'($urandom_range(0, 3)));
    repeat (70) send_beat('0, 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_queue_edges();
    test_arp_styles();
    test_random_phases();
    test_output_backpressure();
    test_steady_stream();
    wait_results();
    repeat (END_SETTLE) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
